### sv/rmps_pkg.sv
`timescale 1ns / 1ps

package rmps_pkg;

	localparam int TIME_BITS  = 24;
	localparam int FIELD_W    = TIME_BITS;
	localparam int MODE_W     = 3;
	localparam int IN_DATA_W  = 2 * FIELD_W;
	localparam int EVT_W      = 16;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 3'd0,
		MODE_APPEND   = 3'd1,
		MODE_START    = 3'd2,
		MODE_STOP     = 3'd3,
		MODE_PAUSE    = 3'd4,
		MODE_CONTINUE = 3'd5,
		MODE_ABORT    = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RUN   = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   has_entries;
		logic   out_free;
	} dp_stat_t;

endpackage

### sv/repeating_multichannel_pulse_sequencer.sv
`timescale 1ns / 1ps
// Pulse pattern sequencer with a table of up to MAX_ENTRIES pulses.
// Input words arrive on the s_ channel: s_tuser holds the command (tick, append,
// start, stop, pause, continue, abort) and s_tdata the pulse offset and duration
// used by append. Every accepted word yields exactly one result word on the m_
// channel, carrying on and off event masks, restart, stop acknowledge, reject
// and the phase after the command.
// The loop pause must be written through cfg_wen and cfg_wdata only while the
// block is idle; the block itself does not enforce this. Any command other
// than a tick while running with entries loaded goes straight from acceptance
// to the finish state, where its result is registered. A tick while running
// with entries loaded walks them through one read port of the pulse table, one
// entry a cycle, then passes the last state and the finish state, where its
// result is registered; a new word is accepted only after the finish state.
// The result is held in an output register; the next word is accepted while it
// waits. If the receiver stalls, a finished command holds until the register
// frees, and no further word is accepted meanwhile.
// Reset empties the table, clears all progress, sets the loop pause to zero and
// returns to the idle phase; it takes effect at once with no clearing pass.

module repeating_multichannel_pulse_sequencer import rmps_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_offset [23:0], entry_duration [47:24]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode [2:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// on_events [15:0], off_events [31:16], period_restarted [32], stop_ack [33],
	// rejected [34], phase_now [36:35], zero [39:37]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wen,
	input  logic [FIELD_W-1:0]    cfg_wdata
);

	localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNTW = $clog2(MAX_ENTRIES + 1);

	dp_cmd_t         cmd;
	dp_stat_t        stat;
	logic [IDXW-1:0] rd_idx;
	logic [CNTW-1:0] cnt;

	rmps_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cnt      (cnt),
		.cmd      (cmd),
		.rd_idx   (rd_idx)
	);

	rmps_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.stat      (stat),
		.cnt       (cnt),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### sv/rmps_ctrl.sv
`timescale 1ns / 1ps

module rmps_ctrl import rmps_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [MODE_W-1:0]  s_tuser,
	input  dp_stat_t           stat,
	input  logic [CNTW-1:0]    cnt,
	output dp_cmd_t            cmd,
	output logic [IDXW-1:0]    rd_idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_LAST,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [IDXW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (mode_t'(s_tuser) == MODE_TICK && stat.phase == PH_RUN &&
						    stat.has_entries) begin
							state_q <= ST_WALK;
							idx_q   <= '0;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WALK: begin
					if (CNTW'(idx_q) + CNTW'(1) == cnt) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + IDXW'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.rd_en  = (state_q == ST_WALK);
	assign cmd.commit = (state_q == ST_FIN) && stat.out_free;
	assign rd_idx     = idx_q;

endmodule

### sv/rmps_dp.sv
`timescale 1ns / 1ps

module rmps_dp import rmps_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [IDXW-1:0]       rd_idx,
	output dp_stat_t              stat,
	output logic [CNTW-1:0]       cnt,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  cfg_wen,
	input  logic [FIELD_W-1:0]    cfg_wdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int TW  = TIME_BITS;
	localparam int EW  = TW + 1;
	localparam int PW  = TW + 2;
	localparam int ELW = TW + 3;
	localparam int MW  = EW + TW;

	mode_t            mode_q;
	logic [TW-1:0]    off_in_q;
	logic [TW-1:0]    dur_in_q;
	logic [TW-1:0]    lp_q;

	logic [MW-1:0]    mem_q [MAX_ENTRIES];
	logic [MW-1:0]    rd_s1;
	logic [IDXW-1:0]  idx_s1;
	logic             ev_v_s1;

	logic [MAX_ENTRIES-1:0] on_q;
	logic [MAX_ENTRIES-1:0] done_q;
	logic [CNTW-1:0]  cnt_q;
	logic [ELW-1:0]   el_q;
	phase_t           phase_q;
	logic             pending_q;
	logic [EVT_W-1:0] on_ev_q;
	logic [EVT_W-1:0] off_ev_q;
	logic             m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [TW-1:0]    rd_off;
	logic [EW-1:0]    rd_end;
	logic             el_nonneg;
	logic             hit_on;
	logic             hit_off;
	logic             e_on;
	logic             e_done;
	logic [EVT_W-1:0] ev_hot;
	logic [EVT_W-1:0] start_mask;
	logic             append_ok;
	logic [ELW-1:0]   el_max;

	logic             do_clear;
	logic             do_cnt_zero;
	logic             do_el_zero;
	logic             do_restart;
	logic             do_inc;
	logic             do_append;
	logic             rej;
	logic             ack;
	logic             rst_p;
	logic [EVT_W-1:0] on_o;
	logic [EVT_W-1:0] off_o;
	phase_t           phase_n;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= mode_t'(s_tuser);
			off_in_q <= TW'(s_tdata[FIELD_W-1:0]);
			dur_in_q <= TW'(s_tdata[IN_DATA_W-1:FIELD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
		end else if (cfg_wen) begin
			lp_q <= TW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (do_append && cmd.commit) begin
			mem_q[cnt_q[IDXW-1:0]] <= {EW'(off_in_q) + EW'(dur_in_q), off_in_q};
		end
		if (cmd.rd_en) begin
			rd_s1  <= mem_q[rd_idx];
			idx_s1 <= rd_idx;
		end
	end

	assign rd_off    = rd_s1[TW-1:0];
	assign rd_end    = rd_s1[MW-1:TW];
	assign el_nonneg = !el_q[ELW-1];
	assign hit_on    = el_nonneg && (PW'(rd_off) <= el_q[PW-1:0]);
	assign hit_off   = el_nonneg && (PW'(rd_end) <= el_q[PW-1:0]);
	assign e_on      = on_q[idx_s1];
	assign e_done    = done_q[idx_s1];
	assign append_ok = (phase_q == PH_IDLE) && (32'(cnt_q) < MAX_ENTRIES);
	assign el_max    = {1'b0, {(ELW-1){1'b1}}};

	always_comb begin
		for (int b = 0; b < EVT_W; b++) begin
			ev_hot[b]     = (32'(idx_s1) == b);
			start_mask[b] = (32'(cnt_q) > b);
		end
	end

	always_comb begin
		do_clear    = 1'b0;
		do_cnt_zero = 1'b0;
		do_el_zero  = 1'b0;
		do_restart  = 1'b0;
		do_inc      = 1'b0;
		do_append   = 1'b0;
		rej         = 1'b0;
		ack         = 1'b0;
		rst_p       = 1'b0;
		on_o        = '0;
		off_o       = '0;
		phase_n     = phase_q;
		unique case (mode_q)
			MODE_TICK: begin
				if (phase_q == PH_RUN) begin
					on_o  = on_ev_q;
					off_o = off_ev_q;
					if (!pending_q) begin
						do_clear   = 1'b1;
						do_restart = 1'b1;
						rst_p      = 1'b1;
					end else if (el_q != el_max) begin
						do_inc = 1'b1;
					end
				end
			end
			MODE_APPEND: begin
				if (append_ok) begin
					do_append = 1'b1;
				end else begin
					rej = 1'b1;
				end
			end
			MODE_START: begin
				if (phase_q == PH_IDLE) begin
					off_o      = start_mask;
					do_clear   = 1'b1;
					do_el_zero = 1'b1;
					phase_n    = PH_RUN;
				end else begin
					rej = 1'b1;
				end
			end
			MODE_STOP: begin
				if (phase_q == PH_PAUSE) begin
					rej = 1'b1;
				end else begin
					do_clear    = 1'b1;
					do_cnt_zero = 1'b1;
					do_el_zero  = 1'b1;
					phase_n     = PH_IDLE;
					ack         = 1'b1;
				end
			end
			MODE_PAUSE: begin
				if (phase_q == PH_RUN) begin
					do_clear = 1'b1;
					phase_n  = PH_PAUSE;
				end else begin
					rej = 1'b1;
				end
			end
			MODE_CONTINUE: begin
				if (phase_q == PH_PAUSE) begin
					do_el_zero = 1'b1;
					phase_n    = PH_RUN;
				end else begin
					rej = 1'b1;
				end
			end
			MODE_ABORT: begin
				do_clear    = 1'b1;
				do_cnt_zero = 1'b1;
				do_el_zero  = 1'b1;
				phase_n     = PH_IDLE;
			end
			default: begin
				rej = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q       <= '0;
			done_q     <= '0;
			cnt_q      <= '0;
			el_q       <= '0;
			phase_q    <= PH_IDLE;
			pending_q  <= 1'b0;
			on_ev_q    <= '0;
			off_ev_q   <= '0;
			ev_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			ev_v_s1 <= cmd.rd_en;
			if (cmd.accept) begin
				pending_q <= 1'b0;
				on_ev_q   <= '0;
				off_ev_q  <= '0;
			end
			if (ev_v_s1 && !e_done) begin
				pending_q <= 1'b1;
				if (e_on) begin
					if (hit_off) begin
						done_q[idx_s1] <= 1'b1;
						off_ev_q       <= off_ev_q | ev_hot;
					end
				end else if (hit_on) begin
					on_q[idx_s1] <= 1'b1;
					on_ev_q      <= on_ev_q | ev_hot;
				end
			end
			if (cmd.commit) begin
				phase_q <= phase_n;
				if (do_clear) begin
					on_q   <= '0;
					done_q <= '0;
				end
				if (do_append) begin
					on_q[cnt_q[IDXW-1:0]]   <= 1'b0;
					done_q[cnt_q[IDXW-1:0]] <= 1'b0;
					cnt_q                   <= cnt_q + CNTW'(1);
				end
				if (do_cnt_zero) begin
					cnt_q <= '0;
				end
				if (do_el_zero) begin
					el_q <= '0;
				end
				if (do_restart) begin
					el_q <= ELW'(0) - ELW'(lp_q);
				end
				if (do_inc) begin
					el_q <= el_q + ELW'(1);
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= OUT_DATA_W'({phase_n, rej, ack, rst_p, off_o, on_o});
		end
	end

	assign stat.phase       = phase_q;
	assign stat.has_entries = (cnt_q != '0);
	assign stat.out_free    = !m_tvalid_q || m_tready;
	assign cnt              = cnt_q;
	assign m_tvalid         = m_tvalid_q;
	assign m_tdata          = m_tdata_q;

endmodule

### sv/rmps_chk.sv
`timescale 1ns / 1ps

module rmps_chk import rmps_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [EVT_W-1:0] on_ev;
	logic [EVT_W-1:0] off_ev;
	logic             restarted;
	logic             ack;
	logic [1:0]       ph;

	assign on_ev     = m_tdata[15:0];
	assign off_ev    = m_tdata[31:16];
	assign restarted = m_tdata[32];
	assign ack       = m_tdata[33];
	assign ph        = m_tdata[36:35];

	// A word stalled by the receiver is held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// No entry can switch on and off in the same word.
	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (on_ev & off_ev) == '0)
		else $error("entry reported both on and off");

	// A restart happens only when nothing changed, and the sequence keeps running.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && restarted |-> on_ev == '0 && off_ev == '0 && ph == PH_RUN)
		else $error("restart word inconsistent");

	// A stop acknowledge leaves the block idle without driving outputs.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ack |-> ph == PH_IDLE && on_ev == '0 && off_ev == '0 && !restarted)
		else $error("stop acknowledge word inconsistent");

endmodule

bind repeating_multichannel_pulse_sequencer rmps_chk u_chk (.*);

### test/rmps_result_check.sv
`timescale 1ns / 1ps

module rmps_result_check import rmps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wen,
	input  logic [FIELD_W-1:0]    cfg_wdata,
	output int                    errors,
	output int                    outstanding
);

	localparam int TABLE_SIZE = 16;
	localparam logic signed [FIELD_W+2:0] ELAPSED_TOP = {1'b0, {(FIELD_W+2){1'b1}}};

	typedef struct packed {
		logic [EVT_W-1:0] on_events;
		logic [EVT_W-1:0] off_events;
		logic             period_restarted;
		logic             stop_ack;
		logic             rejected;
		logic [1:0]       phase_now;
	} pulse_result_t;

	logic [FIELD_W-1:0]        pulse_start [TABLE_SIZE];
	logic [FIELD_W-1:0]        pulse_len [TABLE_SIZE];
	logic [TABLE_SIZE-1:0]     lit;
	logic [TABLE_SIZE-1:0]     finished;
	int                        loaded;
	logic signed [FIELD_W+2:0] elapsed;
	phase_t                    phase_q;
	logic [FIELD_W-1:0]        gap_ticks;
	pulse_result_t             expected_words [$];

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s differs, expected %0h, got %0h", $time, what, want, got);
		errors++;
	endtask

	function automatic void end_sequence();
		lit = '0;
		finished = '0;
		loaded = 0;
		elapsed = '0;
		phase_q = PH_IDLE;
	endfunction

	function automatic pulse_result_t predict_word(logic [MODE_W-1:0] mode,
			logic [FIELD_W-1:0] offset, logic [FIELD_W-1:0] duration);
		pulse_result_t r;
		logic busy;
		logic [FIELD_W:0] stop_at;
		r = '0;
		case (mode)
		MODE_TICK: begin
			if (phase_q == PH_RUN) begin
				busy = 1'b0;
				for (int i = 0; i < loaded; i++) begin
					if (!finished[i]) begin
						busy = 1'b1;
						if (lit[i]) begin
							stop_at = {1'b0, pulse_start[i]} + {1'b0, pulse_len[i]};
							if (elapsed >= 0 && $signed({2'b00, stop_at}) <= elapsed) begin
								finished[i] = 1'b1;
								r.off_events[i] = 1'b1;
							end
						end else if (elapsed >= 0 &&
								$signed({3'b000, pulse_start[i]}) <= elapsed) begin
							lit[i] = 1'b1;
							r.on_events[i] = 1'b1;
						end
					end
				end
				if (!busy) begin
					lit = '0;
					finished = '0;
					elapsed = -$signed({3'b000, gap_ticks});
					r.period_restarted = 1'b1;
				end else if (elapsed < ELAPSED_TOP) begin
					elapsed = elapsed + (FIELD_W+3)'(1);
				end
			end
		end
		MODE_APPEND: begin
			if (phase_q == PH_IDLE && loaded < TABLE_SIZE) begin
				pulse_start[loaded] = offset;
				pulse_len[loaded] = duration;
				lit[loaded] = 1'b0;
				finished[loaded] = 1'b0;
				loaded++;
			end else begin
				r.rejected = 1'b1;
			end
		end
		MODE_START: begin
			if (phase_q == PH_IDLE) begin
				for (int i = 0; i < loaded; i++)
					r.off_events[i] = 1'b1;
				lit = '0;
				finished = '0;
				elapsed = '0;
				phase_q = PH_RUN;
			end else begin
				r.rejected = 1'b1;
			end
		end
		MODE_STOP: begin
			if (phase_q == PH_PAUSE) begin
				r.rejected = 1'b1;
			end else begin
				end_sequence();
				r.stop_ack = 1'b1;
			end
		end
		MODE_PAUSE: begin
			if (phase_q == PH_RUN) begin
				lit = '0;
				finished = '0;
				phase_q = PH_PAUSE;
			end else begin
				r.rejected = 1'b1;
			end
		end
		MODE_CONTINUE: begin
			if (phase_q == PH_PAUSE) begin
				elapsed = '0;
				phase_q = PH_RUN;
			end else begin
				r.rejected = 1'b1;
			end
		end
		MODE_ABORT: begin
			end_sequence();
		end
		default: begin
			r.rejected = 1'b1;
		end
		endcase
		r.phase_now = phase_q;
		return r;
	endfunction

	always @(posedge clk) begin
		pulse_result_t got;
		pulse_result_t want;
		if (!arst_n) begin
			end_sequence();
			gap_ticks = '0;
			expected_words.delete();
		end else begin
			if (cfg_wen)
				gap_ticks = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got.on_events = m_tdata[15:0];
				got.off_events = m_tdata[31:16];
				got.period_restarted = m_tdata[32];
				got.stop_ack = m_tdata[33];
				got.rejected = m_tdata[34];
				got.phase_now = m_tdata[36:35];
				if (expected_words.size() == 0) begin
					report("unexpected word", 32'd0, m_tdata[31:0]);
				end else begin
					want = expected_words.pop_front();
					if (got.on_events !== want.on_events)
						report("on_events", 32'(want.on_events), 32'(got.on_events));
					if (got.off_events !== want.off_events)
						report("off_events", 32'(want.off_events), 32'(got.off_events));
					if (got.period_restarted !== want.period_restarted)
						report("period_restarted", 32'(want.period_restarted),
							32'(got.period_restarted));
					if (got.stop_ack !== want.stop_ack)
						report("stop_ack", 32'(want.stop_ack), 32'(got.stop_ack));
					if (got.rejected !== want.rejected)
						report("rejected", 32'(want.rejected), 32'(got.rejected));
					if (got.phase_now !== want.phase_now)
						report("phase_now", 32'(want.phase_now), 32'(got.phase_now));
				end
			end
			if (s_tvalid && s_tready)
				expected_words.insert(expected_words.size(),
					predict_word(s_tuser, s_tdata[FIELD_W-1:0],
					s_tdata[IN_DATA_W-1:FIELD_W]));
		end
		outstanding <= expected_words.size();
	end

endmodule

### test/tb_repeating_multichannel_pulse_sequencer.sv
`timescale 1ns / 1ps

module tb_repeating_multichannel_pulse_sequencer;
	import rmps_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
	localparam int HOLD_CYCLES   = 200;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 25;
	localparam int WORDS_PER_RUN = 150;
	localparam int RUN_COUNT     = 5;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wen;
	logic [FIELD_W-1:0]    cfg_wdata;
	int                    errors;
	int                    outstanding;
	int                    words_sent = 0;
	bit                    idle_on = 1'b0;
	bit                    hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	repeating_multichannel_pulse_sequencer #(
		.MAX_ENTRIES(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	rmps_result_check result_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	function automatic logic [FIELD_W-1:0] pick_time();
		logic [FIELD_W-1:0] t;
		t = FIELD_W'($urandom);
		if ($urandom_range(0, 11) != 0)
			t = FIELD_W'($urandom_range(0, 6));
		return t;
	endfunction

	task automatic send_word(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] offset,
			logic [FIELD_W-1:0] duration);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {duration, offset};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_cmd(logic [MODE_W-1:0] mode);
		send_word(mode, pick_time(), pick_time());
	endtask

	task automatic run_sequence();
		int entries;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4))
				send_word(MODE_W'($urandom_range(0, 7)), FIELD_W'($urandom),
					FIELD_W'($urandom));
		end else begin
			send_cmd($urandom_range(0, 1) ? MODE_ABORT : MODE_STOP);
			entries = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
			repeat (entries) send_cmd(MODE_APPEND);
			send_cmd(MODE_START);
			repeat ($urandom_range(4, 30)) begin
				case ($urandom_range(0, 29))
				0: begin
					send_cmd(MODE_PAUSE);
					repeat ($urandom_range(0, 2)) send_cmd(MODE_TICK);
					send_cmd(MODE_CONTINUE);
				end
				1: send_word(MODE_W'($urandom_range(0, 7)), FIELD_W'($urandom),
					FIELD_W'($urandom));
				default: send_cmd(MODE_TICK);
				endcase
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_loop_pause(logic [FIELD_W-1:0] value);
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
				m_tready <= 1'b1;
			end else if (idle_on && m_tready && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_repeating_multichannel_pulse_sequencer: done, errors");
		$finish;
	end

	initial begin
		logic [FIELD_W-1:0] pause_values [RUN_COUNT];
		pause_values[0] = 24'd3;
		pause_values[1] = 24'hFFFFFF;
		pause_values[2] = 24'd0;
		pause_values[3] = FIELD_W'($urandom_range(1, 5));
		pause_values[4] = 24'd1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_TICK;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cmd(MODE_TICK);
		send_cmd(MODE_PAUSE);
		send_cmd(MODE_CONTINUE);
		send_cmd(MODE_UNUSED);
		send_cmd(MODE_STOP);
		send_cmd(MODE_START);
		send_cmd(MODE_TICK);
		send_cmd(MODE_APPEND);
		send_cmd(MODE_START);
		send_cmd(MODE_CONTINUE);
		send_cmd(MODE_PAUSE);
		send_cmd(MODE_TICK);
		send_cmd(MODE_STOP);
		send_cmd(MODE_START);
		send_cmd(MODE_CONTINUE);
		send_cmd(MODE_ABORT);
		send_word(MODE_APPEND, 24'd0, 24'd0);
		send_word(MODE_APPEND, 24'hFFFFFF, 24'hFFFFFF);
		send_word(MODE_APPEND, 24'd1, 24'd2);
		send_cmd(MODE_START);
		repeat (4) send_cmd(MODE_TICK);
		send_cmd(MODE_STOP);
		send_cmd(MODE_ABORT);

		for (int run = 0; run < RUN_COUNT; run++) begin
			send_cmd(MODE_ABORT);
			drain();
			write_loop_pause(pause_values[run]);
			if (run == 2)
				hold_req = 1'b1;
			while (words_sent < WORDS_PER_RUN * (run + 1)) begin
				idle_on = (run < RUN_COUNT - 1) && ($urandom_range(0, 3) != 0);
				run_sequence();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_repeating_multichannel_pulse_sequencer: done, clean");
		else
			$display("tb_repeating_multichannel_pulse_sequencer: done, errors");
		$finish;
	end

endmodule
